// ----- rtl/core/hpack_representation_tokenizer_assert.svh -----
// Assertion macros shared by the header block tokenizer modules.
`ifndef HPACK_REPRESENTATION_TOKENIZER_ASSERT_SVH
`define HPACK_REPRESENTATION_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define HRT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hpack tokenizer assertion failed");
`define HRT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) \
        else $error("hpack tokenizer assertion failed");
`else
`define HRT_ASSERT(label, clk, rst_n, prop)
`define HRT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ----- rtl/core/hpack_rt_pkg.sv -----
// Types and constants of the header block tokenizer.
`default_nettype none

package hpack_rt_pkg;

    localparam int INT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH   = 4;

    // Token kinds.
    localparam logic [3:0] KIND_INDEXED   = 4'd0;
    localparam logic [3:0] KIND_LIT_INCR  = 4'd1;
    localparam logic [3:0] KIND_LIT_NOIDX = 4'd2;
    localparam logic [3:0] KIND_LIT_NEVER = 4'd3;
    localparam logic [3:0] KIND_SIZE      = 4'd4;
    localparam logic [3:0] KIND_NAME_STR  = 4'd5;
    localparam logic [3:0] KIND_VALUE_STR = 4'd6;
    localparam logic [3:0] KIND_STR_BYTE  = 4'd7;
    localparam logic [3:0] KIND_BLOCK_OK  = 4'd8;
    localparam logic [3:0] KIND_ERROR     = 4'd9;

    // Error codes.
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_ZERO_INDEX  = 3'd1;
    localparam logic [2:0] ERR_ZERO_SIZE   = 3'd2;
    localparam logic [2:0] ERR_ZERO_LENGTH = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW    = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd5;

    // Representation kinds, numbered as the matching token kinds.
    localparam logic [2:0] REP_INDEXED   = 3'd0;
    localparam logic [2:0] REP_LIT_INCR  = 3'd1;
    localparam logic [2:0] REP_LIT_NOIDX = 3'd2;
    localparam logic [2:0] REP_LIT_NEVER = 3'd3;
    localparam logic [2:0] REP_SIZE      = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       block_end;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] token_value;
        logic        huffman_flag;
        logic [7:0]  data_byte;
        logic [2:0]  error_code;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] token_value;
        logic        huffman_flag;
        logic [7:0]  data_byte;
        logic [2:0]  error_code;
    } t_token;

    // Work for the back end: an optional token and an optional block end token.
    typedef struct packed {
        logic   tok_valid;
        t_token tok;
        logic   end_valid;
        logic   end_ok;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/core/hpack_representation_tokenizer.sv -----
// HPACK header block tokenizer: top level joining the front end, queue and back end.
//
// Usage: header block octets enter on the input channel (i_valid, o_stall, i_data),
// one octet per transaction, with block_end set on the last octet of a block.
// Tokens leave on the output channel (o_valid, i_stall, o_data); an octet gives
// zero, one or two tokens, and last_result marks the last token of an octet.
// The first token of an octet passes through a command queue slot and the output
// register before it appears on o_data.
// Throughput: one octet per cycle while the queue is not full, limited by the single
// output register that issues one token per cycle while the receiver does not stall;
// an octet with two tokens (block end) issues them one after the other, and the four-entry
// command queue absorbs the surplus. The front end decodes one continuation octet per
// cycle, while the queue is not full, with one shift and one add of the integer width.
// Reset (synchronous, active low) returns the parser to the start of a
// representation and empties the queue and the output register.
// When the receiver stalls, the output token holds; the front end keeps taking
// octets until the queue is full, and then raises o_stall.
`default_nettype none

module hpack_representation_tokenizer #(
    parameter int INT_WIDTH = hpack_rt_pkg::INT_WIDTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  hpack_rt_pkg::t_in_item  i_data,
    output logic                    o_valid,
    input  wire                     i_stall,
    output hpack_rt_pkg::t_out_item o_data
);

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    hpack_rt_pkg::t_cmd w_wcmd;
    hpack_rt_pkg::t_cmd w_rcmd;

    hpack_rt_front #(
        .INT_WIDTH(INT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (w_push),
        .o_cmd   (w_wcmd),
        .i_full  (w_full)
    );

    hpack_rt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wcmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_rcmd),
        .o_empty (w_empty)
    );

    hpack_rt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_rcmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

// ----- rtl/core/hpack_rt_front.sv -----
// Front end: accepts header octets, tracks the parse phase and forms token commands.
`default_nettype none
`include "hpack_representation_tokenizer_assert.svh"

module hpack_rt_front #(
    parameter int INT_WIDTH = hpack_rt_pkg::INT_WIDTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  hpack_rt_pkg::t_in_item i_data,
    output logic                   o_push,
    output hpack_rt_pkg::t_cmd     o_cmd,
    input  wire                    i_full
);

    localparam int SW = $clog2(INT_WIDTH + 8);
    localparam int VW = (INT_WIDTH > 32) ? INT_WIDTH : 32;

    typedef enum logic [5:0] {
        PH_START     = 6'b000001,
        PH_INT       = 6'b000010,
        PH_SLEN      = 6'b000100,
        PH_SLEN_CONT = 6'b001000,
        PH_SDATA     = 6'b010000,
        PH_SKIP      = 6'b100000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_kind, n_kind;
    logic [INT_WIDTH-1:0]   r_accum, n_accum;
    logic [SW-1:0]          r_shift, n_shift;
    logic                   r_huff, n_huff;
    logic [INT_WIDTH-1:0]   r_bytes_left, n_bytes_left;
    logic                   r_value_pending, n_value_pending;

    logic                   w_accept;
    logic [7:0]             w_b;
    logic [6:0]             w_bits;
    logic [INT_WIDTH+6:0]   w_shifted;
    logic [INT_WIDTH:0]     w_sum;
    logic                   w_shift_full;
    logic                   w_ovf;
    logic [INT_WIDTH-1:0]   w_cont_accum;
    logic [SW-1:0]          w_cont_shift;
    logic [INT_WIDTH-1:0]   w_bl_dec;

    logic                   w_do_rep;
    logic                   w_do_len;
    logic                   w_do_fail;
    logic [2:0]             w_fail_code;
    logic [INT_WIDTH-1:0]   w_act_val;
    logic [VW-1:0]          w_val_wide;

    assign w_accept = i_valid && !i_full;
    assign o_stall  = i_full;
    assign w_b      = i_data.in_byte;
    assign w_bits   = w_b[6:0];

    // One continuation octet: the 7-bit group goes in at the current shift, and any set
    // bit beyond the integer width, or a carry out of the add, is an overflow.
    assign w_shift_full = (r_shift >= SW'(INT_WIDTH));
    assign w_shifted    = {{INT_WIDTH{1'b0}}, w_bits} << r_shift;
    assign w_sum        = {1'b0, r_accum} + {1'b0, w_shifted[INT_WIDTH-1:0]};
    assign w_ovf        = (w_bits != 7'd0) &&
                          (w_shift_full || (w_shifted[INT_WIDTH+6:INT_WIDTH] != 7'd0) ||
                           w_sum[INT_WIDTH]);
    assign w_cont_accum = (w_bits != 7'd0) ? w_sum[INT_WIDTH-1:0] : r_accum;
    assign w_cont_shift = w_shift_full ? r_shift : r_shift + SW'(7);
    assign w_bl_dec     = (r_bytes_left != '0) ? r_bytes_left - INT_WIDTH'(1) : r_bytes_left;

    always_comb begin
        n_phase         = r_phase;
        n_kind          = r_kind;
        n_accum         = r_accum;
        n_shift         = r_shift;
        n_huff          = r_huff;
        n_bytes_left    = r_bytes_left;
        n_value_pending = r_value_pending;
        w_do_rep        = 1'b0;
        w_do_len        = 1'b0;
        w_do_fail       = 1'b0;
        w_fail_code     = hpack_rt_pkg::ERR_NONE;
        w_act_val       = '0;
        o_cmd           = '0;

        unique case (r_phase)
            PH_START: begin
                if (w_b[7]) begin
                    n_kind = hpack_rt_pkg::REP_INDEXED;
                    if (w_b[6:0] == 7'h00) begin
                        w_do_fail   = 1'b1;
                        w_fail_code = hpack_rt_pkg::ERR_ZERO_INDEX;
                    end else if (w_b[6:0] == 7'h7F) begin
                        n_phase = PH_INT;
                        n_accum = INT_WIDTH'(w_b[6:0]);
                        n_shift = '0;
                    end else begin
                        w_do_rep  = 1'b1;
                        w_act_val = INT_WIDTH'(w_b[6:0]);
                    end
                end else if (w_b[6]) begin
                    n_kind = hpack_rt_pkg::REP_LIT_INCR;
                    if (w_b[5:0] == 6'h3F) begin
                        n_phase = PH_INT;
                        n_accum = INT_WIDTH'(w_b[5:0]);
                        n_shift = '0;
                    end else begin
                        w_do_rep  = 1'b1;
                        w_act_val = INT_WIDTH'(w_b[5:0]);
                    end
                end else if (w_b[5]) begin
                    n_kind = hpack_rt_pkg::REP_SIZE;
                    if (w_b[4:0] == 5'h00) begin
                        w_do_fail   = 1'b1;
                        w_fail_code = hpack_rt_pkg::ERR_ZERO_SIZE;
                    end else if (w_b[4:0] == 5'h1F) begin
                        n_phase = PH_INT;
                        n_accum = INT_WIDTH'(w_b[4:0]);
                        n_shift = '0;
                    end else begin
                        w_do_rep  = 1'b1;
                        w_act_val = INT_WIDTH'(w_b[4:0]);
                    end
                end else begin
                    n_kind = w_b[4] ? hpack_rt_pkg::REP_LIT_NEVER : hpack_rt_pkg::REP_LIT_NOIDX;
                    if (w_b[3:0] == 4'hF) begin
                        n_phase = PH_INT;
                        n_accum = INT_WIDTH'(w_b[3:0]);
                        n_shift = '0;
                    end else begin
                        w_do_rep  = 1'b1;
                        w_act_val = INT_WIDTH'(w_b[3:0]);
                    end
                end
            end
            PH_INT: begin
                if (w_ovf) begin
                    w_do_fail   = 1'b1;
                    w_fail_code = hpack_rt_pkg::ERR_OVERFLOW;
                end else begin
                    n_accum = w_cont_accum;
                    n_shift = w_cont_shift;
                    if (!w_b[7]) begin
                        w_do_rep  = 1'b1;
                        w_act_val = w_cont_accum;
                    end
                end
            end
            PH_SLEN: begin
                n_huff = w_b[7];
                if (w_b[6:0] == 7'h00) begin
                    w_do_fail   = 1'b1;
                    w_fail_code = hpack_rt_pkg::ERR_ZERO_LENGTH;
                end else if (w_b[6:0] == 7'h7F) begin
                    n_phase = PH_SLEN_CONT;
                    n_accum = INT_WIDTH'(w_b[6:0]);
                    n_shift = '0;
                end else begin
                    w_do_len  = 1'b1;
                    w_act_val = INT_WIDTH'(w_b[6:0]);
                end
            end
            PH_SLEN_CONT: begin
                if (w_ovf) begin
                    w_do_fail   = 1'b1;
                    w_fail_code = hpack_rt_pkg::ERR_OVERFLOW;
                end else begin
                    n_accum = w_cont_accum;
                    n_shift = w_cont_shift;
                    if (!w_b[7]) begin
                        w_do_len  = 1'b1;
                        w_act_val = w_cont_accum;
                    end
                end
            end
            PH_SDATA: begin
                o_cmd.tok_valid     = 1'b1;
                o_cmd.tok.token_kind = hpack_rt_pkg::KIND_STR_BYTE;
                o_cmd.tok.data_byte = w_b;
                n_bytes_left        = w_bl_dec;
                if (w_bl_dec == '0) begin
                    // A finished name string is followed by the value string.
                    n_value_pending = !r_value_pending;
                    n_phase         = r_value_pending ? PH_START : PH_SLEN;
                end
            end
            PH_SKIP: begin
            end
            default: begin
            end
        endcase

        w_val_wide = VW'(w_act_val);

        if (w_do_rep) begin
            o_cmd.tok_valid       = 1'b1;
            o_cmd.tok.token_kind  = {1'b0, n_kind};
            o_cmd.tok.token_value = w_val_wide[31:0];
            if (n_kind == hpack_rt_pkg::REP_LIT_INCR || n_kind == hpack_rt_pkg::REP_LIT_NOIDX ||
                n_kind == hpack_rt_pkg::REP_LIT_NEVER) begin
                // Name index zero means a literal name string comes first.
                n_value_pending = (w_act_val != '0);
                n_phase         = PH_SLEN;
            end else begin
                n_phase = PH_START;
            end
        end

        if (w_do_len) begin
            o_cmd.tok_valid         = 1'b1;
            o_cmd.tok.token_kind    = r_value_pending ? hpack_rt_pkg::KIND_VALUE_STR
                                                      : hpack_rt_pkg::KIND_NAME_STR;
            o_cmd.tok.token_value   = w_val_wide[31:0];
            o_cmd.tok.huffman_flag  = n_huff;
            n_bytes_left            = w_act_val;
            n_phase                 = PH_SDATA;
        end

        if (w_do_fail) begin
            o_cmd.tok_valid      = 1'b1;
            o_cmd.tok.token_kind = hpack_rt_pkg::KIND_ERROR;
            o_cmd.tok.error_code = w_fail_code;
            n_phase              = PH_SKIP;
        end

        // Nothing more is said for a block whose error has already been reported.
        o_cmd.end_valid = i_data.block_end && (n_phase != PH_SKIP);
        o_cmd.end_ok    = (n_phase == PH_START);

        if (i_data.block_end) begin
            n_phase         = PH_START;
            n_kind          = hpack_rt_pkg::REP_INDEXED;
            n_accum         = '0;
            n_shift         = '0;
            n_huff          = 1'b0;
            n_bytes_left    = '0;
            n_value_pending = 1'b0;
        end
    end

    assign o_push = w_accept && (o_cmd.tok_valid || o_cmd.end_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_START;
            r_kind          <= hpack_rt_pkg::REP_INDEXED;
            r_accum         <= '0;
            r_shift         <= '0;
            r_huff          <= 1'b0;
            r_bytes_left    <= '0;
            r_value_pending <= 1'b0;
        end else if (w_accept) begin
            r_phase         <= n_phase;
            r_kind          <= n_kind;
            r_accum         <= n_accum;
            r_shift         <= n_shift;
            r_huff          <= n_huff;
            r_bytes_left    <= n_bytes_left;
            r_value_pending <= n_value_pending;
        end
    end

    `HRT_ASSERT_NEXT(a_front_end_restart, i_clk, i_rst_n, w_accept && i_data.block_end, r_phase == PH_START)
    `HRT_ASSERT(a_front_sdata_left, i_clk, i_rst_n, (r_phase == PH_SDATA) |-> (r_bytes_left != '0))

endmodule

`default_nettype wire

// ----- rtl/core/hpack_rt_queue.sv -----
// Short command queue between the front and back ends of the tokenizer.
`default_nettype none
`include "hpack_representation_tokenizer_assert.svh"

module hpack_rt_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  hpack_rt_pkg::t_cmd i_wdata,
    output logic               o_full,
    input  wire                i_pop,
    output hpack_rt_pkg::t_cmd o_rdata,
    output logic               o_empty
);

    localparam int DEPTH = hpack_rt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    hpack_rt_pkg::t_cmd r_slot [DEPTH];
    logic [PW-1:0]      r_wr, r_rd;
    logic [CW-1:0]      r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    `HRT_ASSERT(a_queue_no_overrun, i_clk, i_rst_n, i_push |-> !o_full)
    `HRT_ASSERT(a_queue_no_underrun, i_clk, i_rst_n, i_pop |-> !o_empty)

endmodule

`default_nettype wire

// ----- rtl/core/hpack_rt_back.sv -----
// Back end: turns queued commands into result transactions through an output register.
`default_nettype none
`include "hpack_representation_tokenizer_assert.svh"

module hpack_rt_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  hpack_rt_pkg::t_cmd      i_cmd,
    input  wire                     i_empty,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire                     i_stall,
    output hpack_rt_pkg::t_out_item o_data
);

    logic                    r_valid, n_valid;
    logic                    r_second, n_second;
    hpack_rt_pkg::t_out_item r_out, n_out;
    logic                    w_load;

    assign w_load = !r_valid || !i_stall;

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_out    = r_out;
        o_pop    = 1'b0;
        if (w_load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                if (i_cmd.tok_valid && !r_second) begin
                    n_out.token_kind   = i_cmd.tok.token_kind;
                    n_out.token_value  = i_cmd.tok.token_value;
                    n_out.huffman_flag = i_cmd.tok.huffman_flag;
                    n_out.data_byte    = i_cmd.tok.data_byte;
                    n_out.error_code   = i_cmd.tok.error_code;
                    n_out.last_result  = !i_cmd.end_valid;
                    // Keep the entry when its block end token is still to come.
                    if (i_cmd.end_valid) begin
                        n_second = 1'b1;
                    end else begin
                        o_pop = 1'b1;
                    end
                end else begin
                    n_out.token_kind   = i_cmd.end_ok ? hpack_rt_pkg::KIND_BLOCK_OK
                                                      : hpack_rt_pkg::KIND_ERROR;
                    n_out.token_value  = '0;
                    n_out.huffman_flag = 1'b0;
                    n_out.data_byte    = '0;
                    n_out.error_code   = i_cmd.end_ok ? hpack_rt_pkg::ERR_NONE
                                                      : hpack_rt_pkg::ERR_TRUNCATED;
                    n_out.last_result  = 1'b1;
                    n_second           = 1'b0;
                    o_pop              = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

    `HRT_ASSERT(a_back_second_held, i_clk, i_rst_n, r_second |-> (!i_empty && i_cmd.end_valid))

endmodule

`default_nettype wire
